>>> rtl/mstk_pkg.sv
// ----------------------------------------------------------------------------
// mstk_pkg
// Shared types and constants for the stack with running minimum: default
// sizes, operation and error codes, and the shift control of one cell lane.
// ----------------------------------------------------------------------------
`default_nettype none

package mstk_pkg;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountWidth = 7;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_e;

  // Shift control of one lane of cells.
  typedef struct packed {
    logic push;  // every cell takes the entry above it
    logic pop;   // every cell takes the entry below it
  } shift_t;

endpackage

`default_nettype wire

>>> rtl/mstk_cell.sv
// ----------------------------------------------------------------------------
// mstk_cell
// One stack entry. Shifts down toward the bottom on a push and up toward the
// top on a pop, otherwise holds its value.
// ----------------------------------------------------------------------------
`default_nettype none

module mstk_cell #(
  parameter int unsigned VALUE_WIDTH = mstk_pkg::ValueWidth
) (
  input  wire logic                   clk_i,
  input  wire mstk_pkg::shift_t       shift_i,
  input  wire logic [VALUE_WIDTH-1:0] above_i,
  input  wire logic [VALUE_WIDTH-1:0] below_i,
  output logic      [VALUE_WIDTH-1:0] value_o
);

  logic [VALUE_WIDTH-1:0] value_q;
  logic [VALUE_WIDTH-1:0] value_d;

  always_comb begin
    priority if (shift_i.push) begin
      value_d = above_i;
    end else if (shift_i.pop) begin
      value_d = below_i;
    end else begin
      value_d = value_q;
    end
  end

  // Payload only: contents are undefined until written.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

>>> rtl/mstk_chain.sv
// ----------------------------------------------------------------------------
// mstk_chain
// A row of cells forming one shift stack. Cell 0 is the top; a push enters
// at the top and a pop pulls every entry one place up.
// ----------------------------------------------------------------------------
`default_nettype none

module mstk_chain #(
  parameter int unsigned STACK_DEPTH = mstk_pkg::StackDepth,
  parameter int unsigned VALUE_WIDTH = mstk_pkg::ValueWidth
) (
  input  wire logic                   clk_i,
  input  wire mstk_pkg::shift_t       shift_i,
  input  wire logic [VALUE_WIDTH-1:0] push_value_i,
  output logic      [VALUE_WIDTH-1:0] top_o,
  output logic      [VALUE_WIDTH-1:0] next_o
);

  logic [VALUE_WIDTH-1:0] cell_q [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] above;
    logic [VALUE_WIDTH-1:0] below;

    if (i == 0) begin : g_first
      assign above = push_value_i;
    end else begin : g_rest
      assign above = cell_q[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner
      assign below = cell_q[i+1];
    end

    mstk_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .shift_i(shift_i),
      .above_i(above),
      .below_i(below),
      .value_o(cell_q[i])
    );
  end

  assign top_o  = cell_q[0];
  assign next_o = cell_q[1];

endmodule

`default_nettype wire

>>> rtl/stack_with_running_minimum_top.sv
// ----------------------------------------------------------------------------
// stack_with_running_minimum_top
// Push/pop stack of signed values that also reports the least value held.
// The result strobe is registered: it rises in the cycle after an item is accepted.
// Throughput: one item per cycle; busy stays low, as every operation is a
// single shift of the value and minimum cell rows and a count update.
// Reset clears both counts (stack empty); cell contents stay undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_with_running_minimum_top #(
  parameter int unsigned STACK_DEPTH = mstk_pkg::StackDepth,
  parameter int unsigned VALUE_WIDTH = mstk_pkg::ValueWidth
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            opcode_i,
  input  wire logic [VALUE_WIDTH-1:0]          push_value_i,
  output logic                                 result_valid_o,
  output logic      [VALUE_WIDTH-1:0]          top_value_o,
  output logic      [VALUE_WIDTH-1:0]          min_value_o,
  output logic      [mstk_pkg::CountWidth-1:0] entry_count_o,
  output logic                                 is_empty_o,
  output logic      [1:0]                      error_code_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ExtW = CntW + mstk_pkg::CountWidth;

  logic                   accept;
  logic                   is_push;
  logic                   push_ok;
  logic                   pop_ok;
  logic                   min_push;
  logic                   min_pop;
  mstk_pkg::shift_t       val_shift;
  mstk_pkg::shift_t       min_shift;
  logic [VALUE_WIDTH-1:0] val_top;
  logic [VALUE_WIDTH-1:0] val_next;
  logic [VALUE_WIDTH-1:0] min_top;
  logic [VALUE_WIDTH-1:0] min_next;
  logic [CntW-1:0]        val_cnt_q, val_cnt_d;
  logic [CntW-1:0]        min_cnt_q, min_cnt_d;
  logic [ExtW-1:0]        cnt_ext;
  mstk_pkg::err_e         err;
  logic [VALUE_WIDTH-1:0] top_d;
  logic [VALUE_WIDTH-1:0] min_d;

  logic                            valid_q;
  logic [VALUE_WIDTH-1:0]          top_q;
  logic [VALUE_WIDTH-1:0]          minv_q;
  logic [mstk_pkg::CountWidth-1:0] count_q;
  logic                            empty_q;
  logic [1:0]                      err_q;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign is_push = (mstk_pkg::op_e'(opcode_i) == mstk_pkg::OP_PUSH);

  always_comb begin
    push_ok  = accept && is_push && (val_cnt_q != CntW'(STACK_DEPTH));
    pop_ok   = accept && !is_push && (val_cnt_q != '0);
    // New value joins the minimum row when it ties or beats the current minimum.
    min_push = push_ok &&
               ((min_cnt_q == '0) || ($signed(push_value_i) <= $signed(min_top)));
    min_pop  = pop_ok && (min_cnt_q != '0) && (min_top == val_top);

    val_shift.push = push_ok;
    val_shift.pop  = pop_ok;
    min_shift.push = min_push;
    min_shift.pop  = min_pop;

    val_cnt_d = val_cnt_q;
    if (push_ok) val_cnt_d = val_cnt_q + CntW'(1);
    if (pop_ok)  val_cnt_d = val_cnt_q - CntW'(1);
    min_cnt_d = min_cnt_q;
    if (min_push) min_cnt_d = min_cnt_q + CntW'(1);
    if (min_pop)  min_cnt_d = min_cnt_q - CntW'(1);

    err = mstk_pkg::ERR_OK;
    if (accept && is_push && !push_ok)  err = mstk_pkg::ERR_FULL;
    if (accept && !is_push && !pop_ok)  err = mstk_pkg::ERR_EMPTY;

    // Tops after this item, forwarded from the cells before they shift.
    priority if (push_ok) top_d = push_value_i;
    else if (pop_ok)      top_d = val_next;
    else                  top_d = val_top;

    priority if (min_push) min_d = push_value_i;
    else if (min_pop)      min_d = min_next;
    else                   min_d = min_top;

    if (val_cnt_d == '0) begin
      top_d = '0;
      min_d = '0;
    end

    cnt_ext = ExtW'(val_cnt_d);
  end

  mstk_chain #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_val_chain (
    .clk_i       (clk_i),
    .shift_i     (val_shift),
    .push_value_i(push_value_i),
    .top_o       (val_top),
    .next_o      (val_next)
  );

  mstk_chain #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_min_chain (
    .clk_i       (clk_i),
    .shift_i     (min_shift),
    .push_value_i(push_value_i),
    .top_o       (min_top),
    .next_o      (min_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_cnt_q <= '0;
      min_cnt_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      val_cnt_q <= val_cnt_d;
      min_cnt_q <= min_cnt_d;
      valid_q   <= accept;
    end
  end

  // Result payload: load on every accepted item.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      top_q   <= top_d;
      minv_q  <= min_d;
      count_q <= cnt_ext[mstk_pkg::CountWidth-1:0];
      empty_q <= (val_cnt_d == '0);
      err_q   <= err;
    end
  end

  assign result_valid_o = valid_q;
  assign top_value_o    = top_q;
  assign min_value_o    = minv_q;
  assign entry_count_o  = count_q;
  assign is_empty_o     = empty_q;
  assign error_code_o   = err_q;

endmodule

`default_nettype wire
